// ===== hw/rtl/mtlb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtlb_pkg
// Shared types and constants of the 32-entry joint TLB.
// ----------------------------------------------------------------------------
package mtlb_pkg;

	localparam int NUM_ENTRIES = 32;
	localparam int IDX_W       = 5;
	localparam int DIV_STEPS   = 31;
	localparam int DCNT_W      = 5;

	localparam logic [2:0] OP_READ      = 3'd0;
	localparam logic [2:0] OP_WRITE_IDX = 3'd1;
	localparam logic [2:0] OP_WRITE_RND = 3'd2;
	localparam logic [2:0] OP_PROBE     = 3'd3;
	localparam logic [2:0] OP_XLATE     = 3'd4;

	localparam logic [31:0] KSEG_LIMIT = 32'hC000_0000;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [4:0]  entry_index;
		logic [31:0] entry_hi;
		logic [31:0] entry_lo_even;
		logic [31:0] entry_lo_odd;
		logic [31:0] page_mask;
		logic [31:0] cycle_count;
		logic [31:0] vaddr;
		logic        is_store;
	} in_t;

	typedef struct packed {
		logic [31:0] mask_out;
		logic [31:0] hi_out;
		logic [31:0] lo_even_out;
		logic [31:0] lo_odd_out;
		logic [31:0] probe_result;
		logic [4:0]  written_index;
		logic [31:0] paddr;
		logic        miss;
	} out_t;

	typedef struct packed {
		logic [18:0] vpn2;
		logic [11:0] mask;
		logic [7:0]  asid;
		logic        glob;
	} tag_t;

	typedef struct packed {
		logic [23:0] pfn;
		logic [2:0]  cache;
		logic        dirty;
		logic        valid;
	} page_t;

	typedef struct packed {
		logic capture;
		logic div_init;
		logic div_step;
		logic wr_en;
		logic scan_init;
		logic scan_range;
		logic scan_check;
		logic res_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       div_done;
		logic       hit;
		logic       last;
	} stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mtlb_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtlb_dp
// Entry storage, random-index remainder unit, entry scan and result register.
// ----------------------------------------------------------------------------
module mtlb_dp (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire mtlb_pkg::in_t   in_data,
	input  wire logic            cfg_wr_en,
	input  wire logic [4:0]      cfg_wr_data,
	input  wire mtlb_pkg::cmd_t  cmd,
	output mtlb_pkg::stat_t      stat,
	output mtlb_pkg::out_t       out_data
);

	mtlb_pkg::in_t   in_q;
	logic [4:0]      wired_q;
	mtlb_pkg::tag_t  tag_q  [mtlb_pkg::NUM_ENTRIES];
	mtlb_pkg::page_t even_q [mtlb_pkg::NUM_ENTRIES];
	mtlb_pkg::page_t odd_q  [mtlb_pkg::NUM_ENTRIES];

	// remainder unit
	logic [30:0]                 quo_q;
	logic [5:0]                  rem_q;
	logic [5:0]                  dvs_q;
	logic [mtlb_pkg::DCNT_W-1:0] dcnt_q;
	logic [6:0]                  trial;

	// scan
	logic [mtlb_pkg::IDX_W-1:0] scan_q;
	logic                       found_q;
	logic [31:0]                pa_q;
	logic [31:0]                s0_s1, e0_s1, s1_s1, e1_s1, d0_s1, d1_s1;
	logic [4:0]                 k_q;

	logic [mtlb_pkg::IDX_W-1:0] rd_addr;
	logic [mtlb_pkg::IDX_W-1:0] wr_addr;
	mtlb_pkg::tag_t             rt;
	mtlb_pkg::page_t            rp0, rp1;
	logic                       scan_op;
	logic [31:0]                s0, len, vp;
	logic                       ok0, ok1, pmatch, hit;
	logic [31:0]                base0, base1, pa;
	mtlb_pkg::out_t             res;

	assign scan_op = (in_q.opcode == mtlb_pkg::OP_PROBE) || (in_q.opcode == mtlb_pkg::OP_XLATE);
	assign rd_addr = scan_op ? scan_q : in_q.entry_index;
	assign rt  = tag_q[rd_addr];
	assign rp0 = even_q[rd_addr];
	assign rp1 = odd_q[rd_addr];

	assign trial   = {rem_q, quo_q[30]};
	assign wr_addr = (in_q.opcode == mtlb_pkg::OP_WRITE_RND) ? (rem_q[4:0] + wired_q)
		: in_q.entry_index;

	// range stage operands
	assign s0  = {rt.vpn2, 13'd0};
	assign len = {8'd0, rt.mask, 12'hFFF};
	assign vp  = {in_q.vaddr[31:12], 12'd0};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			in_q <= in_data;
		end
		if (cmd.scan_range) begin
			s0_s1 <= s0;
			e0_s1 <= s0 + len;
			s1_s1 <= s0 + {7'd0, 13'(rt.mask + 12'd0) + 13'd1, 12'd0};
			e1_s1 <= s0 + {7'd0, rt.mask, 13'h1FFF};
			d0_s1 <= vp - s0;
			d1_s1 <= vp - s0 - {7'd0, 13'(rt.mask + 12'd0) + 13'd1, 12'd0};
		end
	end

	// check stage: even half has priority over odd half
	always_comb begin
		ok0 = rp0.valid && (s0_s1 < e0_s1) && !(s0_s1[31] && (e0_s1 < mtlb_pkg::KSEG_LIMIT))
			&& (rp0.pfn[23:17] == 7'd0) && (!in_q.is_store || rp0.dirty)
			&& (vp >= s0_s1) && (vp < e0_s1);
		ok1 = rp1.valid && (s1_s1 < e1_s1) && !(s1_s1[31] && (e1_s1 < mtlb_pkg::KSEG_LIMIT))
			&& (rp1.pfn[23:17] == 7'd0) && (!in_q.is_store || rp1.dirty)
			&& (vp >= s1_s1) && (vp < e1_s1);
		base0  = {rp0.pfn[19:0], 12'd0} + d0_s1;
		base1  = {rp1.pfn[19:0], 12'd0} + d1_s1;
		pa     = {1'b1, (ok0 ? base0[30:12] : base1[30:12]), in_q.vaddr[11:0]};
		pmatch = (((rt.vpn2 ^ in_q.entry_hi[31:13]) & ~{7'd0, rt.mask}) == 19'd0)
			&& (rt.glob || (rt.asid == in_q.entry_hi[7:0]));
		hit    = (in_q.opcode == mtlb_pkg::OP_PROBE) ? pmatch : (ok0 || ok1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wired_q <= '0;
			for (int i = 0; i < mtlb_pkg::NUM_ENTRIES; i++) begin
				tag_q[i]  <= '0;
				even_q[i] <= '0;
				odd_q[i]  <= '0;
			end
			dcnt_q  <= '0;
			scan_q  <= '0;
			found_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				wired_q <= cfg_wr_data;
			end
			if (cmd.div_init) begin
				dcnt_q <= '0;
			end else if (cmd.div_step) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (cmd.wr_en) begin
				tag_q[wr_addr]  <= {in_q.entry_hi[31:13], in_q.page_mask[24:13],
					in_q.entry_hi[7:0], in_q.entry_lo_even[0] & in_q.entry_lo_odd[0]};
				even_q[wr_addr] <= in_q.entry_lo_even[29:1];
				odd_q[wr_addr]  <= in_q.entry_lo_odd[29:1];
			end
			if (cmd.scan_init) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else if (cmd.scan_check) begin
				if (hit) begin
					found_q <= 1'b1;
				end else if (scan_q != mtlb_pkg::IDX_W'(mtlb_pkg::NUM_ENTRIES - 1)) begin
					scan_q <= scan_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			quo_q <= in_q.cycle_count[31:1];
			rem_q <= '0;
			dvs_q <= 6'(mtlb_pkg::NUM_ENTRIES) - {1'b0, wired_q};
		end else if (cmd.div_step) begin
			quo_q <= {quo_q[29:0], 1'b0};
			rem_q <= (trial >= {1'b0, dvs_q}) ? 6'(trial - {1'b0, dvs_q}) : trial[5:0];
		end
		if (cmd.wr_en) begin
			k_q <= wr_addr;
		end
		if (cmd.scan_check && hit) begin
			pa_q <= pa;
		end
	end

	always_comb begin
		res = '0;
		case (in_q.opcode)
			mtlb_pkg::OP_READ: begin
				res.mask_out    = {7'd0, rt.mask, 13'd0};
				res.hi_out      = {rt.vpn2, 5'd0, rt.asid};
				res.lo_even_out = {2'd0, rp0.pfn, rp0.cache, rp0.dirty, rp0.valid, rt.glob};
				res.lo_odd_out  = {2'd0, rp1.pfn, rp1.cache, rp1.dirty, rp1.valid, rt.glob};
			end
			mtlb_pkg::OP_WRITE_IDX, mtlb_pkg::OP_WRITE_RND: begin
				res.written_index = k_q;
			end
			mtlb_pkg::OP_PROBE: begin
				res.probe_result = found_q ? {27'd0, scan_q}
					: {1'b1, 26'd0, in_q.entry_index};
			end
			mtlb_pkg::OP_XLATE: begin
				res.paddr = found_q ? pa_q : 32'd0;
				res.miss  = !found_q;
			end
			default: begin
				res = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_data <= res;
		end
	end

	assign stat.op       = in_q.opcode;
	assign stat.div_done = (dcnt_q == mtlb_pkg::DCNT_W'(mtlb_pkg::DIV_STEPS));
	assign stat.hit      = hit;
	assign stat.last     = (scan_q == mtlb_pkg::IDX_W'(mtlb_pkg::NUM_ENTRIES - 1));

`ifndef SYNTHESIS
	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |=> (rem_q < dvs_q))
		else $error("remainder not below divisor");
	a_scan_holds_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_check && hit) |=> (found_q && $stable(scan_q)))
		else $error("scan index moved on hit");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/mtlb_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mtlb_ctrl
// Operation sequencer: dispatch, remainder steps, entry scan, result hand-off.
// ----------------------------------------------------------------------------
module mtlb_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	input  wire mtlb_pkg::stat_t stat,
	output mtlb_pkg::cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_DISPATCH, S_DIV, S_WRITE, S_RANGE, S_CHECK, S_FIN
	} state_t;

	state_t state_q, state_d;
	logic   out_free;

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid || !out_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				case (stat.op)
					mtlb_pkg::OP_WRITE_IDX: state_d = S_WRITE;
					mtlb_pkg::OP_WRITE_RND: begin
						cmd.div_init = 1'b1;
						state_d      = S_DIV;
					end
					mtlb_pkg::OP_PROBE, mtlb_pkg::OP_XLATE: begin
						cmd.scan_init = 1'b1;
						state_d       = S_RANGE;
					end
					default: state_d = S_FIN;
				endcase
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_WRITE;
				end else begin
					cmd.div_step = 1'b1;
				end
			end
			S_WRITE: begin
				cmd.wr_en = 1'b1;
				state_d   = S_FIN;
			end
			S_RANGE: begin
				cmd.scan_range = 1'b1;
				state_d        = S_CHECK;
			end
			S_CHECK: begin
				cmd.scan_check = 1'b1;
				state_d        = (stat.hit || stat.last) ? S_FIN : S_RANGE;
			end
			S_FIN: begin
				if (out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

`ifndef SYNTHESIS
	a_capture_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_DISPATCH))
		else $error("transfer in not followed by dispatch");
	a_fin_presents: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (out_valid && state_q == S_IDLE))
		else $error("result not presented");
	a_one_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RANGE) |=> (state_q == S_CHECK))
		else $error("range stage not followed by check");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/mips_tlb_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mips_tlb_unit
// 32-entry joint TLB: read, write indexed/random, probe, translate.
// Write random runs 31 remainder steps, one bit per cycle. Probe/translate
// scan the entries upward from entry 0, a range state then a check state
// per entry, stopping at the lowest matching entry. One item in flight;
// the next input is taken while the previous result waits in the output
// register.
// Reset: all entries zero, wired zero, ready at once.
// ----------------------------------------------------------------------------
module mips_tlb_unit (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire mtlb_pkg::in_t  in_data,
	output logic                out_valid,
	input  wire logic           out_stall,
	output mtlb_pkg::out_t      out_data,
	input  wire logic           cfg_wr_en,
	input  wire logic [4:0]     cfg_wr_data
);

	mtlb_pkg::cmd_t  cmd;   // sequencer -> datapath
	mtlb_pkg::stat_t stat;  // datapath -> sequencer

	// Sequencer: one state per phase, entry scan alternates range/check.
	mtlb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: entry flops, remainder unit, compare stages, result register.
	mtlb_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.stat        (stat),
		.out_data    (out_data)
	);

endmodule
`default_nettype wire

// ===== sim/mips_tlb_unit_tb.sv =====
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// mips_tlb_unit_tb
// Self-checking bench for the 32-entry joint TLB. A behavioral TLB model
// predicts each result; a queue-fed driver and a clocked monitor exercise
// read, write indexed/random, probe and translate under random idling.
// ----------------------------------------------------------------------------
module mips_tlb_unit_tb;

	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	mtlb_pkg::in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	mtlb_pkg::out_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [4:0] cfg_wr_data = '0;

	mips_tlb_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always #4 clk = ~clk;

	// Model state: tags and the two page halves, plus the wired register.
	mtlb_pkg::tag_t  mdl_tag [mtlb_pkg::NUM_ENTRIES];
	mtlb_pkg::page_t mdl_even [mtlb_pkg::NUM_ENTRIES];
	mtlb_pkg::page_t mdl_odd [mtlb_pkg::NUM_ENTRIES];
	logic [4:0] mdl_wired;

	mtlb_pkg::in_t  pending_items [$];
	mtlb_pkg::out_t expected_results [$];
	int   err_count = 0;
	int   cycle_count = 0;
	bit   quiet_mode = 0;     // last part of the run: no idling
	bit   hold_rx = 0;        // long receiver hold-off request
	int   tx_gap = 0;
	int   rx_gap = 0;

	// Stall seen at the last rising edge, so the driver knows what was taken.
	logic in_stall_q = 1'b0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
		err_count++;
	endtask

	function automatic mtlb_pkg::page_t lo_to_page(input logic [31:0] lo);
		mtlb_pkg::page_t p;
		p.pfn = lo[29:6];
		p.cache = lo[5:3];
		p.dirty = lo[2];
		p.valid = lo[1];
		return p;
	endfunction

	function automatic logic [31:0] page_to_lo(input mtlb_pkg::page_t p, input logic g);
		return {2'b00, p.pfn, p.cache, p.dirty, p.valid, g};
	endfunction

	// Lowest-index translation; returns 1 on a hit.
	function automatic bit tlb_translate(input logic [31:0] va, input logic st,
			output logic [31:0] pa);
		logic [31:0] vp, len, s0, e0, s1, e1, phys, base;
		logic [31:0] s [2];
		logic [31:0] e [2];
		mtlb_pkg::page_t pg;
		vp = va & 32'hFFFF_F000;
		pa = '0;
		for (int k = 0; k < mtlb_pkg::NUM_ENTRIES; k++) begin
			len = ({20'd0, mdl_tag[k].mask} << 12) + 32'hFFF;
			s0 = {mdl_tag[k].vpn2, 13'd0};
			e0 = s0 + len;
			s1 = e0 + 32'd1;
			e1 = s1 + len;
			s[0] = s0; e[0] = e0; s[1] = s1; e[1] = e1;
			for (int h = 0; h < 2; h++) begin
				pg = (h == 0) ? mdl_even[k] : mdl_odd[k];
				phys = {8'd0, pg.pfn} << 12;
				if (!pg.valid || !(s[h] < e[h])) continue;
				if (s[h] >= 32'h8000_0000 && e[h] < mtlb_pkg::KSEG_LIMIT) continue;
				if (pg.pfn >= 24'h20000) continue;   // frame base at or above 0x20000000
				if (st && !pg.dirty) continue;
				if (vp >= s[h] && vp < e[h]) begin
					base = phys + (vp - s[h]);
					pa = 32'h8000_0000 | (base & 32'hFFFF_F000) | (va & 32'hFFF);
					return 1;
				end
			end
		end
		return 0;
	endfunction

	function automatic mtlb_pkg::out_t tlb_predict(input mtlb_pkg::in_t it);
		mtlb_pkg::out_t r;
		int k;
		int w;
		logic [31:0] pa;
		r = '0;
		k = it.entry_index;
		case (it.opcode)
			mtlb_pkg::OP_READ: begin
				r.mask_out = {7'd0, mdl_tag[k].mask, 13'd0};
				r.hi_out = {mdl_tag[k].vpn2, 5'd0, mdl_tag[k].asid};
				r.lo_even_out = page_to_lo(mdl_even[k], mdl_tag[k].glob);
				r.lo_odd_out = page_to_lo(mdl_odd[k], mdl_tag[k].glob);
			end
			mtlb_pkg::OP_WRITE_IDX, mtlb_pkg::OP_WRITE_RND: begin
				if (it.opcode == mtlb_pkg::OP_WRITE_RND) begin
					w = mdl_wired;
					k = int'((it.cycle_count >> 1) % (mtlb_pkg::NUM_ENTRIES - w)) + w;
				end
				mdl_tag[k].vpn2 = it.entry_hi[31:13];
				mdl_tag[k].mask = it.page_mask[24:13];
				mdl_tag[k].asid = it.entry_hi[7:0];
				mdl_tag[k].glob = it.entry_lo_even[0] & it.entry_lo_odd[0];
				mdl_even[k] = lo_to_page(it.entry_lo_even);
				mdl_odd[k] = lo_to_page(it.entry_lo_odd);
				r.written_index = k[4:0];
			end
			mtlb_pkg::OP_PROBE: begin
				r.probe_result = {1'b1, 26'd0, it.entry_index};
				for (int i = 0; i < mtlb_pkg::NUM_ENTRIES; i++) begin
					if (((mdl_tag[i].vpn2 ^ it.entry_hi[31:13]) & ~{7'd0, mdl_tag[i].mask})
							== '0 && (mdl_tag[i].glob || mdl_tag[i].asid == it.entry_hi[7:0])) begin
						r.probe_result = 32'(i);
						break;
					end
				end
			end
			mtlb_pkg::OP_XLATE: begin
				if (tlb_translate(it.vaddr, it.is_store, pa)) r.paddr = pa;
				else r.miss = 1'b1;
			end
			default: ;
		endcase
		return r;
	endfunction

	// Driver: holds the payload while stalled, advances on each transfer.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!(in_valid && in_stall_q)) begin
				if (!quiet_mode && tx_gap == 0 && $urandom_range(0, 9) == 0) begin
					in_valid <= 1'b0;
					tx_gap <= $urandom_range(0, 5);
				end else if (tx_gap > 0 && !quiet_mode) begin
					in_valid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (pending_items.size() > 0) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		in_stall_q <= in_stall;
		if (in_valid && !in_stall && arst_n)
			expected_results.push_back(tlb_predict(in_data));
	end

	// Receiver stall: random bursts, or a long hold-off when requested.
	always @(negedge clk) begin
		if (hold_rx) begin
			out_stall <= 1'b1;
		end else if (quiet_mode) begin
			out_stall <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 7) == 0) begin
			rx_gap <= $urandom_range(0, 5);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Monitor: compare each result transfer with the oldest expectation.
	always @(posedge clk) begin
		mtlb_pkg::out_t want;
		cycle_count <= cycle_count + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", out_data.probe_result, '0);
			end else begin
				want = expected_results.pop_front();
				if (out_data.mask_out !== want.mask_out)
					report_mismatch("mask_out", out_data.mask_out, want.mask_out);
				if (out_data.hi_out !== want.hi_out)
					report_mismatch("hi_out", out_data.hi_out, want.hi_out);
				if (out_data.lo_even_out !== want.lo_even_out)
					report_mismatch("lo_even_out", out_data.lo_even_out, want.lo_even_out);
				if (out_data.lo_odd_out !== want.lo_odd_out)
					report_mismatch("lo_odd_out", out_data.lo_odd_out, want.lo_odd_out);
				if (out_data.probe_result !== want.probe_result)
					report_mismatch("probe_result", out_data.probe_result, want.probe_result);
				if (out_data.written_index !== want.written_index)
					report_mismatch("written_index", 32'(out_data.written_index),
						32'(want.written_index));
				if (out_data.paddr !== want.paddr)
					report_mismatch("paddr", out_data.paddr, want.paddr);
				if (out_data.miss !== want.miss)
					report_mismatch("miss", 32'(out_data.miss), 32'(want.miss));
			end
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("mips_tlb_unit_tb: errors");
			$finish;
		end
	end

	// Small pool of page numbers so probes and translations often hit.
	logic [18:0] vpn_pool [8];

	function automatic mtlb_pkg::in_t make_item(input logic [2:0] op);
		mtlb_pkg::in_t it;
		it = '0;
		it.opcode = op;
		it.entry_index = 5'($urandom);
		it.entry_hi = $urandom;
		it.entry_lo_even = $urandom;
		it.entry_lo_odd = $urandom;
		it.page_mask = $urandom;
		it.cycle_count = $urandom;
		it.vaddr = $urandom;
		it.is_store = 1'($urandom);
		if ($urandom_range(0, 3) != 0) begin
			// well-formed: small masks, low frames, pooled VPNs
			it.entry_hi[31:13] = vpn_pool[$urandom_range(0, 7)];
			it.page_mask = ($urandom_range(0, 2) == 0) ? {7'd0, 12'($urandom), 13'd0} : '0;
			it.entry_lo_even[29:25] = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'd0;
			it.entry_lo_odd[29:25] = ($urandom_range(0, 4) == 0) ? 5'($urandom) : 5'd0;
			it.vaddr[31:13] = vpn_pool[$urandom_range(0, 7)];
		end
		return it;
	endfunction

	task automatic wait_drained(input int extra);
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_wired(input logic [4:0] w);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= w;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		mdl_wired = w;
	endtask

	initial begin
		mtlb_pkg::in_t it;
		logic [4:0] wired_set [4];
		for (int i = 0; i < mtlb_pkg::NUM_ENTRIES; i++) begin
			mdl_tag[i] = '0;
			mdl_even[i] = '0;
			mdl_odd[i] = '0;
		end
		mdl_wired = '0;
		for (int i = 0; i < 8; i++) vpn_pool[i] = 19'($urandom);
		vpn_pool[0] = 19'h40000;  // 0x80000000 region, unmapped
		vpn_pool[1] = 19'h7FFFF;  // top of the space, wraps
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: reset contents, extremes, every operation.
		it = make_item(mtlb_pkg::OP_READ); it.entry_index = 5'd0; pending_items.push_back(it);
		it = make_item(mtlb_pkg::OP_READ); it.entry_index = 5'd31; pending_items.push_back(it);
		it = make_item(mtlb_pkg::OP_XLATE); it.vaddr = '0; pending_items.push_back(it);
		it = make_item(mtlb_pkg::OP_PROBE); it.entry_hi = '0; pending_items.push_back(it);
		it = make_item(mtlb_pkg::OP_WRITE_IDX); it.entry_index = 5'd31;
		it.entry_hi = '1; it.entry_lo_even = '1; it.entry_lo_odd = '1; it.page_mask = '1;
		pending_items.push_back(it);
		it = make_item(mtlb_pkg::OP_READ); it.entry_index = 5'd31; pending_items.push_back(it);
		it = make_item(mtlb_pkg::OP_WRITE_IDX); it.entry_index = 5'd0;
		it.entry_hi = 32'h0000_2005; it.entry_lo_even = 32'h0000_0047;
		it.entry_lo_odd = 32'h0000_0083; it.page_mask = '0;
		pending_items.push_back(it);
		it = make_item(mtlb_pkg::OP_XLATE); it.vaddr = 32'h0000_2ABC; it.is_store = 1;
		pending_items.push_back(it);
		it = make_item(mtlb_pkg::OP_XLATE); it.vaddr = 32'h0000_3ABC; it.is_store = 1;
		pending_items.push_back(it);
		it = make_item(mtlb_pkg::OP_XLATE); it.vaddr = 32'h0000_3ABC; it.is_store = 0;
		pending_items.push_back(it);
		it = make_item(mtlb_pkg::OP_PROBE); it.entry_hi = 32'h0000_2005; pending_items.push_back(it);
		it = make_item(mtlb_pkg::OP_PROBE); it.entry_hi = 32'h0000_2006; it.entry_index = 5'd9;
		pending_items.push_back(it);
		it = make_item(mtlb_pkg::OP_WRITE_RND); it.cycle_count = '1; pending_items.push_back(it);
		it = make_item(mtlb_pkg::OP_WRITE_RND); it.cycle_count = '0; pending_items.push_back(it);
		for (int op = 5; op < 8; op++) begin
			it = make_item(3'(op)); pending_items.push_back(it);
		end
		wait_drained(80);

		// Random phases under several wired settings, extremes included.
		wired_set[0] = 5'd31; wired_set[1] = 5'd0; wired_set[2] = 5'($urandom); wired_set[3] = 5'd30;
		for (int ph = 0; ph < 4; ph++) begin
			write_wired(wired_set[ph]);
			if (ph == 3) quiet_mode = 1;
			for (int n = 0; n < 220; n++)
				pending_items.push_back(make_item(3'($urandom_range(0, 5) == 5 ?
					$urandom_range(5, 7) : $urandom_range(0, 4))));
			if (ph == 1) begin
				// long receiver hold-off while the sender keeps offering
				hold_rx = 1;
				repeat (300) @(posedge clk);
				hold_rx = 0;
			end
			wait_drained(80);
		end

		if (err_count == 0) $display("mips_tlb_unit_tb: clean");
		else $display("mips_tlb_unit_tb: errors");
		$finish;
	end

endmodule
`default_nettype wire
